[rtl/core/qph_pkg.sv]
// qph_pkg: shared types and constants of the quadratic probe hash table core
// no dependencies; used by quadratic_probe_hash_table_core

package qph_pkg;

    // payload and register widths
    localparam int KEY_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 3;
    localparam int IDX_W     = 10;

    // key * multiplier + offset fits the product width; PROD_W keeps one bit over it
    localparam int PROD_W        = KEY_W + CFG_W + 1;
    localparam int MOD_STEP_BITS = 7;
    localparam int MOD_STEPS     = PROD_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

    localparam logic [CFG_W-1:0] MULT_RESET   = 16'd23;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 16'd80;

    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } status_t;

endpackage

[rtl/core/quadratic_probe_hash_table_core.sv]
// quadratic_probe_hash_table_core: open-addressing hash table with quadratic probing
// depends on qph_pkg; holds the slot memory, the hash unit and the probe sequencer
//
// usage: an item on s_ (s_action, s_key_value) inserts or searches a nonzero 32-bit
// key; exactly one result item leaves on m_ (m_status, m_slot_index). hash_multiplier
// and hash_offset are written through cfg_valid/cfg_ready/cfg_index/cfg_data, which
// is always ready; write them only while no item is in flight.
// after reset the slot memory is swept clear, one slot a cycle, and s_ready stays low
// until the sweep ends.
// one item at a time: s_ready is high only while the core is idle. a zero key goes
// straight to the result load. otherwise the multiply-add is registered, MOD_STEPS (7)
// steps reduce the sum to the home slot (7 bits per cycle), each probe is a registered
// memory read, then compare and step, and the result is loaded last; probes range from
// 1 to TABLE_SIZE.
// the result register holds its item while m_ready is low; the core waits in its
// final state and takes no new item until that register frees up.

module quadratic_probe_hash_table_core #(
    parameter int TABLE_SIZE = 1021
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [qph_pkg::KEY_W-1:0]       s_key_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [qph_pkg::STATUS_W-1:0]    m_status,
    output logic [qph_pkg::IDX_W-1:0]       m_slot_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qph_pkg::CFG_W-1:0]       cfg_data
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam logic [SLOT_W:0]   TSIZE     = (SLOT_W+1)'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MOD,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t                               state_reg;
    logic [SLOT_W-1:0]                    clr_cnt_reg;
    logic                                 act_reg;
    logic [qph_pkg::KEY_W-1:0]            key_reg;
    logic [qph_pkg::CFG_W-1:0]            mult_reg;
    logic [qph_pkg::CFG_W-1:0]            offset_reg;
    logic [qph_pkg::PROD_W-1:0]           prod_reg;
    logic [qph_pkg::MOD_CNT_W-1:0]        mod_cnt_reg;
    logic [SLOT_W-1:0]                    slot_reg;
    logic [SLOT_W-1:0]                    delta_reg;
    logic [SLOT_W-1:0]                    probe_cnt_reg;
    logic [qph_pkg::KEY_W-1:0]            rd_key_reg;
    qph_pkg::status_t                     res_status_reg;
    logic [SLOT_W-1:0]                    res_slot_reg;
    logic                                 m_valid_reg;
    logic [qph_pkg::STATUS_W-1:0]         m_status_reg;
    logic [qph_pkg::IDX_W-1:0]            m_slot_index_reg;

    logic [qph_pkg::KEY_W-1:0]            slot_mem [TABLE_SIZE];

    logic [qph_pkg::KEY_W+qph_pkg::CFG_W-1:0] mul_full;
    logic [qph_pkg::PROD_W-1:0]           mac_sum;
    logic [SLOT_W-1:0]                    mod_rem;
    logic [SLOT_W:0]                      slot_sum;
    logic [SLOT_W-1:0]                    slot_step;
    logic [SLOT_W:0]                      delta_sum;
    logic [SLOT_W-1:0]                    delta_step;
    logic                                 mem_we;
    logic [SLOT_W-1:0]                    mem_waddr;
    logic [qph_pkg::KEY_W-1:0]            mem_wdata;
    logic                                 slot_empty;
    logic                                 slot_match;
    logic [SLOT_W+qph_pkg::IDX_W-1:0]     res_slot_ext;

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_index_reg;

    // shared multiply-add, registered before the reduction
    assign mul_full = key_reg * mult_reg;
    assign mac_sum  = {1'b0, mul_full} + qph_pkg::PROD_W'(offset_reg);

    // remainder unit: several bits of the product per cycle, msb first
    always_comb begin
        logic [SLOT_W:0] rem;
        rem = {1'b0, slot_reg};
        for (int j = 0; j < qph_pkg::MOD_STEP_BITS; j++) begin
            rem = {rem[SLOT_W-1:0], prod_reg[qph_pkg::PROD_W-1-j]};
            if (rem >= TSIZE) begin
                rem = rem - TSIZE;
            end
        end
        mod_rem = rem[SLOT_W-1:0];
    end

    // next probe: slot += 2i+1 and delta += 2, both mod table size
    always_comb begin
        slot_sum  = {1'b0, slot_reg} + {1'b0, delta_reg};
        slot_step = (slot_sum >= TSIZE) ? SLOT_W'(slot_sum - TSIZE) : slot_sum[SLOT_W-1:0];
        delta_sum = {1'b0, delta_reg} + (SLOT_W+1)'(2);
        delta_step = (delta_sum >= TSIZE) ? SLOT_W'(delta_sum - TSIZE)
                                          : delta_sum[SLOT_W-1:0];
    end

    assign slot_empty = (rd_key_reg == '0);
    assign slot_match = (rd_key_reg == key_reg);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = key_reg;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (state_reg == S_CHECK && act_reg == qph_pkg::ACT_INSERT && slot_empty) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_key_reg <= slot_mem[slot_reg];
    end

    assign res_slot_ext = {{qph_pkg::IDX_W{1'b0}}, res_slot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            mult_reg    <= qph_pkg::MULT_RESET;
            offset_reg  <= qph_pkg::OFFSET_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == qph_pkg::CFG_MULT) begin
                    mult_reg <= cfg_data;
                end else if (cfg_index == qph_pkg::CFG_OFFSET) begin
                    offset_reg <= cfg_data;
                end
            end

            // in the final state the result register is reloaded instead
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
                    if (clr_cnt_reg == LAST_SLOT) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg <= s_action;
                        key_reg <= s_key_value;
                        if (s_key_value == '0) begin
                            res_status_reg <= qph_pkg::ST_ZERO_KEY;
                            res_slot_reg   <= '0;
                            state_reg      <= S_FINISH;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg    <= mac_sum;
                    slot_reg    <= '0;
                    mod_cnt_reg <= '0;
                    state_reg   <= S_MOD;
                end
                S_MOD: begin
                    slot_reg    <= mod_rem;
                    prod_reg    <= prod_reg << qph_pkg::MOD_STEP_BITS;
                    mod_cnt_reg <= mod_cnt_reg + qph_pkg::MOD_CNT_W'(1);
                    if (mod_cnt_reg == qph_pkg::MOD_CNT_W'(qph_pkg::MOD_STEPS - 1)) begin
                        delta_reg     <= SLOT_W'(1);
                        probe_cnt_reg <= '0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (act_reg == qph_pkg::ACT_INSERT && slot_empty) begin
                        res_status_reg <= qph_pkg::ST_INSERTED;
                        res_slot_reg   <= slot_reg;
                        state_reg      <= S_FINISH;
                    end else if (act_reg == qph_pkg::ACT_SEARCH && slot_empty) begin
                        res_status_reg <= qph_pkg::ST_NOT_FOUND;
                        res_slot_reg   <= '0;
                        state_reg      <= S_FINISH;
                    end else if (act_reg == qph_pkg::ACT_SEARCH && slot_match) begin
                        res_status_reg <= qph_pkg::ST_FOUND;
                        res_slot_reg   <= slot_reg;
                        state_reg      <= S_FINISH;
                    end else if (probe_cnt_reg == LAST_SLOT) begin
                        // every slot on the probe path visited
                        res_status_reg <= (act_reg == qph_pkg::ACT_INSERT) ?
                                          qph_pkg::ST_FULL : qph_pkg::ST_NOT_FOUND;
                        res_slot_reg   <= '0;
                        state_reg      <= S_FINISH;
                    end else begin
                        probe_cnt_reg <= probe_cnt_reg + SLOT_W'(1);
                        slot_reg      <= slot_step;
                        delta_reg     <= delta_step;
                        state_reg     <= S_READ;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= res_status_reg;
                        m_slot_index_reg <= res_slot_ext[qph_pkg::IDX_W-1:0];
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[test/quadratic_probe_hash_table_core_tb.sv]
// quadratic_probe_hash_table_core_tb: self-checking testbench of the quadratic probe hash table
// depends on qph_pkg and quadratic_probe_hash_table_core; keeps its own copy of the slot table
// and predicts status and slot index of every insert and search item

module quadratic_probe_hash_table_core_tb;

    localparam int TABLE_SIZE  = 1021;
    localparam int QUIET_LIMIT = 10000;

    localparam int KEY_W     = qph_pkg::KEY_W;
    localparam int IDX_W     = qph_pkg::IDX_W;
    localparam int CFG_W     = qph_pkg::CFG_W;
    localparam int CFG_IDX_W = qph_pkg::CFG_IDX_W;
    localparam int STATUS_W  = qph_pkg::STATUS_W;

    // register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic             act;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        qph_pkg::status_t st;
        logic [IDX_W-1:0] idx;
    } answer_t;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_action     = 1'b0;
    logic [KEY_W-1:0]     s_key_value  = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [IDX_W-1:0]     m_slot_index;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    // shadow of the core state
    logic [KEY_W-1:0] slot_keys [TABLE_SIZE];
    logic [CFG_W-1:0] hash_mult;
    logic [CFG_W-1:0] hash_offset;

    request_t requests [$];
    answer_t  answers_due [$];
    request_t next_req;
    answer_t  want;
    int       queued_count  = 0;
    int       checked_count = 0;
    int       error_count   = 0;
    int       send_gap      = 0;
    int       stall_left    = 0;
    int       quiet_cycles  = 0;
    bit       calm          = 1'b0;

    quadratic_probe_hash_table_core #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_key_value (s_key_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_slot_index(m_slot_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // walks the probe chain of one key and updates the shadow table on insert
    function automatic answer_t probe_table(input logic act, input logic [KEY_W-1:0] key);
        answer_t     ans;
        logic [63:0] mixed;
        int unsigned home;
        int unsigned slot;
        ans.st  = (act == qph_pkg::ACT_INSERT) ? qph_pkg::ST_FULL : qph_pkg::ST_NOT_FOUND;
        ans.idx = '0;
        if (key == '0) begin
            ans.st = qph_pkg::ST_ZERO_KEY;
            return ans;
        end
        mixed = 64'(key) * 64'(hash_mult) + 64'(hash_offset);
        home  = int'(mixed % 64'(TABLE_SIZE));
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
            slot = (home + i * i) % TABLE_SIZE;
            if (slot_keys[slot] == '0) begin
                if (act == qph_pkg::ACT_INSERT) begin
                    slot_keys[slot] = key;
                    ans.st  = qph_pkg::ST_INSERTED;
                    ans.idx = IDX_W'(slot);
                end else begin
                    ans.st = qph_pkg::ST_NOT_FOUND;
                end
                return ans;
            end
            if (act == qph_pkg::ACT_SEARCH && slot_keys[slot] == key) begin
                ans.st  = qph_pkg::ST_FOUND;
                ans.idx = IDX_W'(slot);
                return ans;
            end
        end
        return ans;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do begin
            k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(1, 5000)) : KEY_W'($urandom);
        end while (k == '0);
        return k;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < 50)
            $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_item(input logic act, input logic [KEY_W-1:0] key);
        request_t req;
        req.act = act;
        req.key = key;
        requests.push_back(req);
        queued_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == qph_pkg::CFG_MULT)
            hash_mult = val;
        else if (idx == qph_pkg::CFG_OFFSET)
            hash_offset = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (checked_count != queued_count) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                answers_due.push_back(probe_table(s_action, s_key_value));
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (requests.size() != 0) begin
                    next_req = requests.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= next_req.act;
                    s_key_value <= next_req.key;
                    if (!calm && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected item status %0d slot %0d",
                                              m_status, m_slot_index));
                end else begin
                    want = answers_due.pop_front();
                    checked_count++;
                    if (m_status !== want.st)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  m_status, want.st.name()));
                    if (m_slot_index !== want.idx)
                        report_mismatch($sformatf("slot_index %0d, expected %0d",
                                                  m_slot_index, want.idx));
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall_left <= $urandom_range(0, 17);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[quadratic_probe_hash_table_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] stored_keys [$];
        logic [CFG_W-1:0] mult_sel;
        logic [CFG_W-1:0] offset_sel;
        int               r;
        foreach (slot_keys[i]) slot_keys[i] = '0;
        hash_mult   = qph_pkg::MULT_RESET;
        hash_offset = qph_pkg::OFFSET_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero keys, empty table, duplicates, one shared home slot
        queue_item(qph_pkg::ACT_INSERT, '0);
        queue_item(qph_pkg::ACT_SEARCH, '0);
        queue_item(qph_pkg::ACT_SEARCH, 32'd1);
        queue_item(qph_pkg::ACT_INSERT, 32'd1);
        queue_item(qph_pkg::ACT_SEARCH, 32'd1);
        queue_item(qph_pkg::ACT_INSERT, 32'd1);
        queue_item(qph_pkg::ACT_SEARCH, 32'd1);
        // 23 * 1021 vanishes mod the table size, so these keys collide
        queue_item(qph_pkg::ACT_INSERT, 32'd5);
        queue_item(qph_pkg::ACT_INSERT, 32'd1026);
        queue_item(qph_pkg::ACT_INSERT, 32'd2047);
        queue_item(qph_pkg::ACT_SEARCH, 32'd2047);
        queue_item(qph_pkg::ACT_SEARCH, 32'd3068);
        queue_item(qph_pkg::ACT_INSERT, '1);
        queue_item(qph_pkg::ACT_SEARCH, '1);
        wait_drained();

        // largest multiply-add, plus writes to undecoded indexes
        write_reg(qph_pkg::CFG_MULT, '1);
        write_reg(qph_pkg::CFG_OFFSET, '1);
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, 16'h5a5a);
        queue_item(qph_pkg::ACT_INSERT, '1);
        queue_item(qph_pkg::ACT_SEARCH, '1);
        queue_item(qph_pkg::ACT_INSERT, 32'h8000_0000);
        queue_item(qph_pkg::ACT_SEARCH, 32'h7fff_ffff);
        queue_item(qph_pkg::ACT_SEARCH, 32'h8000_0000);
        wait_drained();

        // every key homes to slot 0: the chain fills, inserts then fail and
        // searches for absent keys run the full probe count
        write_reg(qph_pkg::CFG_MULT, '0);
        write_reg(qph_pkg::CFG_OFFSET, '0);
        for (int n = 0; n < 530; n++) begin
            k = fresh_key();
            stored_keys.push_back(k);
            queue_item(qph_pkg::ACT_INSERT, k);
        end
        for (int n = 0; n < 24; n++) begin
            if (n % 2 == 0)
                queue_item(qph_pkg::ACT_SEARCH,
                           stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            else
                queue_item(qph_pkg::ACT_SEARCH, fresh_key());
        end
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            if (p == 0) begin
                mult_sel   = 16'd1;
                offset_sel = CFG_W'($urandom_range(0, 65535));
            end else begin
                mult_sel   = CFG_W'($urandom_range(2, 65535));
                offset_sel = CFG_W'($urandom_range(0, 65535));
            end
            calm = (p == 4);
            write_reg(qph_pkg::CFG_MULT, mult_sel);
            write_reg(qph_pkg::CFG_OFFSET, offset_sel);
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    k = fresh_key();
                    stored_keys.push_back(k);
                    queue_item(qph_pkg::ACT_INSERT, k);
                end else if (r < 75) begin
                    queue_item(qph_pkg::ACT_SEARCH,
                               stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
                end else if (r < 83) begin
                    queue_item(qph_pkg::ACT_INSERT,
                               stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
                end else if (r < 95) begin
                    queue_item(qph_pkg::ACT_SEARCH, fresh_key());
                end else begin
                    queue_item(1'($urandom_range(0, 1)), '0);
                end
            end
            wait_drained();
        end

        repeat (100) @(posedge aclk);
        if (answers_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
        if (error_count == 0)
            $display("[quadratic_probe_hash_table_core] OK");
        else
            $display("[quadratic_probe_hash_table_core] ERROR");
        $finish;
    end

endmodule
